>>> rtl/assert_macros.svh
// assertion macros for the rtl of the euler to quaternion block
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define E2Q_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define E2Q_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define E2Q_ASSERT(label, clk, rst, prop)
`define E2Q_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

>>> rtl/e2q_pkg.sv
// shared types, constants and the cordic angle table of the euler to quaternion block
// no dependencies
package e2q_pkg;

  localparam int ANGLE_W             = 16;
  localparam int QUAT_W              = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 6;
  localparam int OUT_FRAC_BITS_DEF   = 14;

  localparam int PHASE_W   = 32;
  localparam int CORDIC_W  = 32;
  localparam int ROT_STEPS = 24;
  localparam int LANE_LAT  = 5 + ROT_STEPS;
  localparam int MERGE_LAT = 4;

  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 32'sd652032874;

  localparam logic signed [PHASE_W-1:0] ROT_ANGLE [ROT_STEPS] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81
  };

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  typedef struct packed {
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic signed [PHASE_W-1:0]  z;
    quad_t                      quad;
  } rot_t;

  typedef struct packed {
    logic signed [CORDIC_W-1:0] c;
    logic signed [CORDIC_W-1:0] s;
  } sincos_t;

  typedef struct packed {
    logic signed [QUAT_W-1:0] w;
    logic signed [QUAT_W-1:0] x;
    logic signed [QUAT_W-1:0] y;
    logic signed [QUAT_W-1:0] z;
  } quat_t;

endpackage

>>> rtl/e2q_in_if.sv
// input channel: heading, pitch and roll with valid/ready handshake
// depends on e2q_pkg
interface e2q_in_if;
  import e2q_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] heading;
  logic signed [ANGLE_W-1:0] pitch;
  logic signed [ANGLE_W-1:0] roll;

  modport source (output valid, output heading, output pitch, output roll, input ready);
  modport sink   (input valid, input heading, input pitch, input roll, output ready);
endinterface

>>> rtl/e2q_out_if.sv
// output channel: quaternion parts with valid/ready handshake
// depends on e2q_pkg
interface e2q_out_if;
  import e2q_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [QUAT_W-1:0] quat_w;
  logic signed [QUAT_W-1:0] quat_x;
  logic signed [QUAT_W-1:0] quat_y;
  logic signed [QUAT_W-1:0] quat_z;

  modport source (output valid, output quat_w, output quat_x, output quat_y, output quat_z,
                  input ready);
  modport sink   (input valid, input quat_w, input quat_x, input quat_y, input quat_z,
                  output ready);
endinterface

>>> rtl/e2q_cordic_stage.sv
// one registered cordic micro-rotation in rotation mode
// depends on e2q_pkg
module e2q_cordic_stage #(
  parameter int STEP = 0
) (
  input  logic          clk,
  input  logic          en,
  input  e2q_pkg::rot_t d,
  output e2q_pkg::rot_t q
);
  import e2q_pkg::*;

  rot_t                       nxt;
  logic signed [CORDIC_W-1:0] dx;
  logic signed [CORDIC_W-1:0] dy;

  always_comb begin
    dx  = d.y >>> STEP;
    dy  = d.x >>> STEP;
    nxt = d;
    if (!d.z[PHASE_W-1]) begin
      nxt.x = d.x - dx;
      nxt.y = d.y + dy;
      nxt.z = d.z - ROT_ANGLE[STEP];
    end else begin
      nxt.x = d.x + dx;
      nxt.y = d.y - dy;
      nxt.z = d.z + ROT_ANGLE[STEP];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= nxt;
    end
  end
endmodule

>>> rtl/e2q_lane.sv
// one angle lane: clamp, degree to phase conversion, quadrant fold, cordic, unfold
// depends on e2q_pkg and e2q_cordic_stage
module e2q_lane #(
  parameter int ANGLE_FRAC_BITS = e2q_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [e2q_pkg::ANGLE_W-1:0] angle,
  output e2q_pkg::sincos_t                  sc
);
  import e2q_pkg::*;

  localparam int MAG_W   = 16;
  localparam int FRAC    = 24;
  localparam int RECIP_W = 47 - ANGLE_FRAC_BITS;
  localparam int HI_W    = RECIP_W - FRAC;
  localparam int SUM_W   = MAG_W + RECIP_W + 1;
  localparam int EXT_W   = 32;

  // phase = round(mag * 2^(28-AFB) / 45), the fraction is a multiple of 1/45
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((64'd1 << (52 - ANGLE_FRAC_BITS)) / 64'd45);
  localparam logic [FRAC-1:0]    RECIP_LO = RECIP[FRAC-1:0];
  localparam logic [HI_W-1:0]    RECIP_HI = RECIP[RECIP_W-1:FRAC];
  localparam logic [SUM_W-1:0]   HALF     = SUM_W'(1) << (FRAC - 1);
  localparam logic signed [EXT_W-1:0] LIM = EXT_W'(360 * (2 ** ANGLE_FRAC_BITS));
  localparam logic [PHASE_W-1:0] EIGHTH   = PHASE_W'(1) << (PHASE_W - 3);

  logic signed [EXT_W-1:0] a_ext;
  logic signed [EXT_W-1:0] a_cl;
  logic                    neg1, neg2, neg3;
  logic [MAG_W-1:0]        mag1;
  logic [MAG_W+FRAC-1:0]   plo;
  logic [MAG_W+HI_W-1:0]   phi;
  logic [SUM_W-1:0]        sum;
  logic [PHASE_W-1:0]      m3;
  logic [PHASE_W-1:0]      p;
  logic [PHASE_W-1:0]      t;
  logic [PHASE_W-1:0]      r;
  rot_t                    rot [ROT_STEPS+1];
  sincos_t                 sc_next;

  // clamp to plus or minus a full turn
  always_comb begin
    a_ext = EXT_W'(angle);
    if (a_ext > LIM) begin
      a_cl = LIM;
    end else if (a_ext < -LIM) begin
      a_cl = -LIM;
    end else begin
      a_cl = a_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg1 <= a_cl[EXT_W-1];
      mag1 <= MAG_W'(a_cl[EXT_W-1] ? -a_cl : a_cl);
    end
  end

  // reciprocal multiply split in two partial products
  always_ff @(posedge clk) begin
    if (en) begin
      neg2 <= neg1;
      plo  <= mag1 * RECIP_LO;
      phi  <= mag1 * RECIP_HI;
    end
  end

  assign sum = (SUM_W'(phi) << FRAC) + SUM_W'(plo) + HALF;

  always_ff @(posedge clk) begin
    if (en) begin
      neg3 <= neg2;
      m3   <= PHASE_W'(sum >> FRAC);
    end
  end

  // quadrant fold, residual in [-1/8, 1/8) turn
  always_comb begin
    p = neg3 ? (PHASE_W'(0) - m3) : m3;
    t = p + EIGHTH;
    r = p - {t[PHASE_W-1:PHASE_W-2], {(PHASE_W-2){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot[0].x    <= CORDIC_GAIN;
      rot[0].y    <= '0;
      rot[0].z    <= signed'(r);
      rot[0].quad <= quad_t'(t[PHASE_W-1:PHASE_W-2]);
    end
  end

  for (genvar i = 0; i < ROT_STEPS; i++) begin : g_rot
    e2q_cordic_stage #(
      .STEP(i)
    ) u_stage (
      .clk(clk),
      .en (en),
      .d  (rot[i]),
      .q  (rot[i+1])
    );
  end

  always_comb begin
    unique case (rot[ROT_STEPS].quad)
      QUAD_0: begin
        sc_next.c = rot[ROT_STEPS].x;
        sc_next.s = rot[ROT_STEPS].y;
      end
      QUAD_1: begin
        sc_next.c = -rot[ROT_STEPS].y;
        sc_next.s = rot[ROT_STEPS].x;
      end
      QUAD_2: begin
        sc_next.c = -rot[ROT_STEPS].x;
        sc_next.s = -rot[ROT_STEPS].y;
      end
      QUAD_3: begin
        sc_next.c = rot[ROT_STEPS].y;
        sc_next.s = -rot[ROT_STEPS].x;
      end
      default: begin
        sc_next.c = rot[ROT_STEPS].x;
        sc_next.s = rot[ROT_STEPS].y;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc <= sc_next;
    end
  end
endmodule

>>> rtl/e2q_merge.sv
// combines the three half-angle cosine/sine pairs into the quaternion parts
// depends on e2q_pkg
module e2q_merge #(
  parameter int OUT_FRAC_BITS = e2q_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             en,
  input  e2q_pkg::sincos_t hd,
  input  e2q_pkg::sincos_t pt,
  input  e2q_pkg::sincos_t rl,
  output e2q_pkg::quat_t   q
);
  import e2q_pkg::*;

  localparam int PROD_W = 2 * CORDIC_W;
  localparam logic signed [PROD_W-1:0] PAIR_RND = PROD_W'(1) <<< 29;
  localparam logic signed [PROD_W-1:0] OUT_RND  = PROD_W'(1) <<< (59 - OUT_FRAC_BITS);
  localparam logic signed [PROD_W-1:0] ONE      = PROD_W'(1) <<< OUT_FRAC_BITS;
  localparam int OUT_SH = 60 - OUT_FRAC_BITS;

  logic signed [PROD_W-1:0]   pcc, pss, pcs, psc;
  sincos_t                    rl1, rl2;
  logic signed [CORDIC_W-1:0] acc, ass, acs, asc;
  logic signed [PROD_W-1:0]   t_cc_c, t_ss_s, t_cc_s, t_ss_c;
  logic signed [PROD_W-1:0]   t_cs_c, t_sc_s, t_sc_c, t_cs_s;
  logic signed [PROD_W-1:0]   v [4];
  logic signed [PROD_W-1:0]   sh [4];
  logic signed [PROD_W-1:0]   cl [4];

  // heading by pitch pair products
  always_ff @(posedge clk) begin
    if (en) begin
      pcc <= hd.c * pt.c;
      pss <= hd.s * pt.s;
      pcs <= hd.c * pt.s;
      psc <= hd.s * pt.c;
      rl1 <= rl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc <= CORDIC_W'((pcc + PAIR_RND) >>> 30);
      ass <= CORDIC_W'((pss + PAIR_RND) >>> 30);
      acs <= CORDIC_W'((pcs + PAIR_RND) >>> 30);
      asc <= CORDIC_W'((psc + PAIR_RND) >>> 30);
      rl2 <= rl1;
    end
  end

  // triple products in q60
  always_ff @(posedge clk) begin
    if (en) begin
      t_cc_c <= acc * rl2.c;
      t_ss_s <= ass * rl2.s;
      t_cc_s <= acc * rl2.s;
      t_ss_c <= ass * rl2.c;
      t_cs_c <= acs * rl2.c;
      t_sc_s <= asc * rl2.s;
      t_sc_c <= asc * rl2.c;
      t_cs_s <= acs * rl2.s;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v[0] <= t_cc_c + t_ss_s + OUT_RND;
      v[1] <= t_cc_s - t_ss_c + OUT_RND;
      v[2] <= t_cs_c + t_sc_s + OUT_RND;
      v[3] <= t_sc_c - t_cs_s + OUT_RND;
    end
  end

  // round and saturate to plus or minus one
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sh[k] = v[k] >>> OUT_SH;
      if (sh[k] > ONE) begin
        cl[k] = ONE;
      end else if (sh[k] < -ONE) begin
        cl[k] = -ONE;
      end else begin
        cl[k] = sh[k];
      end
    end
    q.w = QUAT_W'(cl[0]);
    q.x = QUAT_W'(cl[1]);
    q.y = QUAT_W'(cl[2]);
    q.z = QUAT_W'(cl[3]);
  end
endmodule

>>> rtl/euler_to_quaternion.sv
// Euler angles (heading, pitch, roll) to unit quaternion, intrinsic z-y-x order.
// Depends on e2q_pkg, e2q_in_if, e2q_out_if, e2q_lane, e2q_merge and assert_macros.svh.
//
// angles: heading, pitch and roll, signed, 1/64 degree per step at the default
//   scale, clamped to plus or minus 360 degrees. A transaction completes when
//   valid and ready are both high at a rising clk edge.
// quat: quat_w, quat_x, quat_y, quat_z, signed Q2.14 at the default scale,
//   saturated to plus or minus one; same handshake.
// Throughput: one transaction per cycle while ready is high. Three lanes, one per angle,
//   each run a 24-stage cordic pipeline side by side; a four-stage merge forms and sums
//   the triple products.
// Path: an accepted transaction passes the 5 conversion and unfold stages and 24
//   rotation stages of a lane, the 4 merge stages and the output register.
// Reset: rst is synchronous, active high, and empties the pipeline, the output
//   register and the skid register.
// Stall: while quat is held, angles keeps accepting until one more result sits
//   in the skid register; then ready drops and the pipeline freezes until the
//   output register is taken. Items are never dropped or duplicated.
`include "assert_macros.svh"

module euler_to_quaternion #(
  parameter int ANGLE_FRAC_BITS = e2q_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int OUT_FRAC_BITS   = e2q_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  e2q_in_if.sink    angles,
  e2q_out_if.source quat
);
  import e2q_pkg::*;

  localparam int PIPE_LAT = LANE_LAT + MERGE_LAT;

  logic                en;
  logic [PIPE_LAT-1:0] vld;
  sincos_t             sc_hd, sc_pt, sc_rl;
  quat_t               res;
  quat_t               out_q;
  quat_t               skid_q;
  logic                out_valid;
  logic                skid_valid;

  assign en           = !skid_valid;
  assign angles.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_LAT-2:0], angles.valid};
    end
  end

  e2q_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_lane_hd (
    .clk(clk), .en(en), .angle(angles.heading), .sc(sc_hd)
  );

  e2q_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_lane_pt (
    .clk(clk), .en(en), .angle(angles.pitch), .sc(sc_pt)
  );

  e2q_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_lane_rl (
    .clk(clk), .en(en), .angle(angles.roll), .sc(sc_rl)
  );

  e2q_merge #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_merge (
    .clk(clk), .en(en), .hd(sc_hd), .pt(sc_pt), .rl(sc_rl), .q(res)
  );

  // output register plus one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (quat.ready) begin
        out_q      <= skid_q;
        skid_valid <= 1'b0;
      end
    end else if (vld[PIPE_LAT-1]) begin
      if (!out_valid || quat.ready) begin
        out_q     <= res;
        out_valid <= 1'b1;
      end else begin
        skid_q     <= res;
        skid_valid <= 1'b1;
      end
    end else if (quat.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign quat.valid  = out_valid;
  assign quat.quat_w = out_q.w;
  assign quat.quat_x = out_q.x;
  assign quat.quat_y = out_q.y;
  assign quat.quat_z = out_q.z;

  `E2Q_ASSERT(a_skid_needs_out, clk, rst, skid_valid |-> out_valid)
  `E2Q_ASSERT(a_stall_freezes, clk, rst, !en |=> $stable(vld))
  `E2Q_ASSERT(a_skid_on_hold, clk, rst, $rose(skid_valid) |-> $past(out_valid && !quat.ready))
endmodule

>>> dv/quat_compare.sv
// predicts the quaternion of every accepted angle transaction and compares it with the results
// depends on e2q_pkg, e2q_in_if and e2q_out_if
module quat_compare (
  input  logic clk,
  input  logic rst,
  e2q_in_if    angles,
  e2q_out_if   quat,
  output int   mismatches,
  output int   outstanding,
  output int   compared
);
  import e2q_pkg::*;

  localparam int     ANGLE_FRAC = ANGLE_FRAC_BITS_DEF;
  localparam int     OUT_FRAC   = OUT_FRAC_BITS_DEF;
  localparam int     NUM_ROT    = 24;
  localparam longint DEG_LIMIT  = longint'(360) << ANGLE_FRAC;
  localparam longint GAIN_Q30   = 652032874;
  localparam longint ATAN_PHASE [NUM_ROT] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  quat_t expected_quats [$];

  // cosine and sine in q30 of half the angle
  function automatic void half_angle_sincos(input logic signed [ANGLE_W-1:0] raw,
                                            output longint c, output longint s);
    longint   a;
    longint   mag;
    longint   m;
    longint   x;
    longint   y;
    longint   z;
    longint   dx;
    longint   dy;
    bit [31:0] p;
    bit [31:0] r;
    quad_t    quad;
    a = longint'(raw);
    if (a > DEG_LIMIT) a = DEG_LIMIT;
    if (a < -DEG_LIMIT) a = -DEG_LIMIT;
    mag = (a < 0) ? -a : a;
    m = ((mag << (31 - ANGLE_FRAC)) + 180) / 360;
    p = m[31:0];
    if (a < 0) p = -p;
    r = p + 32'h2000_0000;
    quad = quad_t'(r[31:30]);
    r = p - {quad, 30'd0};
    z = longint'($signed(r));
    x = GAIN_Q30;
    y = 0;
    for (int i = 0; i < NUM_ROT; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_PHASE[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_PHASE[i];
      end
    end
    case (quad)
      QUAD_0: begin c = x;  s = y;  end
      QUAD_1: begin c = -y; s = x;  end
      QUAD_2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  // product of three q30 factors in q60
  function automatic longint triple_q60(longint a, longint b, longint c);
    longint ab;
    ab = (a * b + (longint'(1) << 29)) >>> 30;
    return ab * c;
  endfunction

  function automatic logic signed [QUAT_W-1:0] round_sat(longint v);
    longint one;
    longint t;
    one = longint'(1) << OUT_FRAC;
    t = (v + (longint'(1) << (59 - OUT_FRAC))) >>> (60 - OUT_FRAC);
    if (t > one) t = one;
    if (t < -one) t = -one;
    return t[QUAT_W-1:0];
  endfunction

  function automatic quat_t predict_quat(logic signed [ANGLE_W-1:0] heading,
                                         logic signed [ANGLE_W-1:0] pitch,
                                         logic signed [ANGLE_W-1:0] roll);
    longint cps, sps, cth, sth, cph, sph;
    quat_t  q;
    half_angle_sincos(heading, cps, sps);
    half_angle_sincos(pitch, cth, sth);
    half_angle_sincos(roll, cph, sph);
    q.w = round_sat(triple_q60(cps, cth, cph) + triple_q60(sps, sth, sph));
    q.x = round_sat(triple_q60(cps, cth, sph) - triple_q60(sps, sth, cph));
    q.y = round_sat(triple_q60(cps, sth, cph) + triple_q60(sps, cth, sph));
    q.z = round_sat(triple_q60(sps, cth, cph) - triple_q60(cps, sth, sph));
    return q;
  endfunction

  task automatic check_part(string part, logic signed [QUAT_W-1:0] want,
                            logic signed [QUAT_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, part, want, got);
    end
  endtask

  initial begin
    mismatches  = 0;
    outstanding = 0;
    compared    = 0;
  end

  always @(posedge clk) begin
    quat_t want;
    if (!rst) begin
      if (angles.valid && angles.ready)
        expected_quats.push_back(predict_quat(angles.heading, angles.pitch, angles.roll));
      if (quat.valid && quat.ready) begin
        if (expected_quats.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected transaction, expected none, actual %0d %0d %0d %0d",
                   $time, quat.quat_w, quat.quat_x, quat.quat_y, quat.quat_z);
        end else begin
          want = expected_quats.pop_front();
          compared++;
          check_part("quat_w", want.w, quat.quat_w);
          check_part("quat_x", want.x, quat.quat_x);
          check_part("quat_y", want.y, quat.quat_y);
          check_part("quat_z", want.z, quat.quat_z);
        end
      end
    end
    outstanding <= expected_quats.size();
  end
endmodule

>>> dv/tb_top.sv
// drives angle transactions into euler_to_quaternion with random gaps and output stalls
// depends on e2q_pkg, e2q_in_if, e2q_out_if, euler_to_quaternion and quat_compare
module tb_top;
  import e2q_pkg::*;

  localparam int NUM_RANDOM  = 450;
  localparam int DRAIN       = 40;
  localparam int CYCLE_LIMIT = 200000;

  logic clk;
  logic rst;
  bit   steady;
  int   cycles;
  int   mismatches;
  int   outstanding;
  int   compared;
  int   sent;

  e2q_in_if  angles_if ();
  e2q_out_if quat_if ();

  euler_to_quaternion uut (
    .clk    (clk),
    .rst    (rst),
    .angles (angles_if),
    .quat   (quat_if)
  );

  quat_compare quat_cmp (
    .clk         (clk),
    .rst         (rst),
    .angles      (angles_if),
    .quat        (quat_if),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .compared    (compared)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int idle_cycles();
    return steady ? 0 : $urandom_range(0, 3);
  endfunction

  function automatic logic signed [ANGLE_W-1:0] rand_angle();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick <= 5) return ANGLE_W'($urandom_range(0, 46080) - 23040);
    if (pick == 6) return ANGLE_W'($urandom());
    if (pick == 7)
      return ANGLE_W'(5760 * ($urandom_range(0, 8) - 4) + $urandom_range(0, 4) - 2);
    if (pick == 8) return ANGLE_W'($urandom_range(0, 128) - 64);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 1) ? 23040 : -23040;
  endfunction

  task automatic send_angles(logic signed [ANGLE_W-1:0] heading,
                             logic signed [ANGLE_W-1:0] pitch,
                             logic signed [ANGLE_W-1:0] roll);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      angles_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    angles_if.valid   <= 1'b1;
    angles_if.heading <= heading;
    angles_if.pitch   <= pitch;
    angles_if.roll    <= roll;
    @(posedge clk);
    while (!angles_if.ready) @(posedge clk);
    sent++;
  endtask

  // result side stalls
  initial begin
    int hold;
    hold = 0;
    quat_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        quat_if.ready <= 1'b0;
      end else if (quat_if.valid && quat_if.ready) begin
        hold = idle_cycles();
        quat_if.ready <= (hold == 0);
      end else if (hold > 0) begin
        hold = hold - 1;
        quat_if.ready <= (hold == 0);
      end else begin
        quat_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("euler_to_quaternion regression: fail");
        $finish;
      end
    end
  end

  initial begin
    sent   = 0;
    steady = 1'b0;
    rst <= 1'b1;
    angles_if.valid   <= 1'b0;
    angles_if.heading <= '0;
    angles_if.pitch   <= '0;
    angles_if.roll    <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // zero, limits, out of range, quadrant edges, gimbal lock, bit patterns
    send_angles(0, 0, 0);
    send_angles(23040, 23040, 23040);
    send_angles(-23040, -23040, -23040);
    send_angles(32767, -32768, 23041);
    send_angles(-23041, 32767, -32768);
    send_angles(5760, 0, 0);
    send_angles(0, 5760, 0);
    send_angles(0, 0, 5760);
    send_angles(11520, -11520, 11520);
    send_angles(17280, -17280, -5760);
    send_angles(1, -1, 1);
    send_angles(-1, 1, -1);
    send_angles(0, 5760, 11520);
    send_angles(3000, -5760, -7000);
    send_angles(5761, 5759, -5761);
    send_angles(21845, -21846, 21845);
    send_angles(11519, 11521, 17281);
    send_angles(-17279, -11521, 23039);
    send_angles(0, 0, 23040);
    send_angles(-32768, -32768, -32768);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n % 50 == 0) steady = ($urandom_range(0, 3) == 0);
      send_angles(rand_angle(), rand_angle(), rand_angle());
    end
    steady = 1'b0;
    angles_if.valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("sent %0d angle transactions with random gaps and stalls", sent);
    $display("compared %0d quaternions, %0d mismatches", compared, mismatches);
    if (mismatches == 0) begin
      $display("euler_to_quaternion regression: pass");
    end else begin
      $display("euler_to_quaternion regression: fail");
    end
    $finish;
  end
endmodule

>>> euler_to_quaternion.f
+incdir+rtl
rtl/e2q_pkg.sv
rtl/e2q_in_if.sv
rtl/e2q_out_if.sv
rtl/e2q_cordic_stage.sv
rtl/e2q_lane.sv
rtl/e2q_merge.sv
rtl/euler_to_quaternion.sv
dv/quat_compare.sv
dv/tb_top.sv
